// ===== src/sliding_window_median_deviation_unit_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef SLIDING_WINDOW_MEDIAN_DEVIATION_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_DEVIATION_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SWMD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SWMD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/swmd_pkg.sv =====
`default_nettype none
package swmd_pkg;

   localparam int WINDOW_MAX_DEF = 32;
   localparam int SAMPLE_W       = 32;
   localparam int COST_W         = 38;
   localparam int LEN_CFG_W      = 6;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 3;

   localparam logic [CSR_ADDR_W-1:0] ADDR_WINDOW_LEN = 3'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANK,
      ST_MED,
      ST_SUM,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic push;
      logic load;
      logic shift;
      logic rank_en;
      logic rank_clr;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ===== src/swmd_req_if.sv =====
`default_nettype none
interface swmd_req_if import swmd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

// ===== src/swmd_rsp_if.sv =====
`default_nettype none
interface swmd_rsp_if import swmd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [COST_W-1:0] deviation_cost;

   modport source (output valid, output deviation_cost, input ready);
   modport sink (input valid, input deviation_cost, output ready);
endinterface
`default_nettype wire

// ===== src/swmd_cell.sv =====
`default_nettype none
module swmd_cell import swmd_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF,
   parameter int IDX        = 0,
   localparam int IW        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
   localparam int LW        = $clog2(WINDOW_MAX + 1)
) (
   input  wire                        clock,
   input  wire cell_ctl_type          ctl,
   input  wire logic [LW-1:0]         win_len,
   input  wire logic [IW-1:0]         med_pos,
   input  wire logic signed [SAMPLE_W-1:0] hold_prev,
   output logic signed [SAMPLE_W-1:0] hold_out,
   input  wire logic signed [SAMPLE_W-1:0] tok_val_prev,
   input  wire logic [IW-1:0]         tok_idx_prev,
   input  wire logic                  tok_vld_prev,
   input  wire logic                  tok_mark_prev,
   output logic signed [SAMPLE_W-1:0] tok_val_out,
   output logic [IW-1:0]              tok_idx_out,
   output logic                       tok_vld_out,
   output logic                       tok_mark_out
);

   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic signed [SAMPLE_W-1:0] hold_ff, hold_in;
   logic [IW-1:0]              rank_ff, rank_in;
   logic signed [SAMPLE_W-1:0] tok_val_ff, tok_val_in;
   logic [IW-1:0]              tok_idx_ff, tok_idx_in;
   logic                       tok_vld_ff, tok_vld_in;
   logic                       tok_mark_ff, tok_mark_in;
   logic                       own_vld;
   logic                       below;

   assign own_vld = (LW'(IDX) < win_len);

   // A visiting sample ranks below this one if smaller, or equal and from a lower cell.
   assign below = tok_vld_ff && ((tok_val_ff < hold_ff) ||
                  ((tok_val_ff == hold_ff) && (tok_idx_ff < MY_IDX)));

   always_comb begin
      hold_in     = ctl.push ? hold_prev : hold_ff;
      rank_in     = rank_ff;
      tok_val_in  = tok_val_ff;
      tok_idx_in  = tok_idx_ff;
      tok_vld_in  = tok_vld_ff;
      tok_mark_in = tok_mark_ff;
      if (ctl.rank_clr) begin
         rank_in = '0;
      end else if (ctl.rank_en && below) begin
         rank_in = rank_ff + 1'b1;
      end
      if (ctl.load) begin
         tok_val_in  = hold_ff;
         tok_idx_in  = MY_IDX;
         tok_vld_in  = own_vld;
         tok_mark_in = own_vld && (rank_ff == med_pos);
      end else if (ctl.shift) begin
         tok_val_in  = tok_val_prev;
         tok_idx_in  = tok_idx_prev;
         tok_vld_in  = tok_vld_prev;
         tok_mark_in = tok_mark_prev;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      rank_ff     <= rank_in;
      tok_val_ff  <= tok_val_in;
      tok_idx_ff  <= tok_idx_in;
      tok_vld_ff  <= tok_vld_in;
      tok_mark_ff <= tok_mark_in;
   end

   assign hold_out     = hold_ff;
   assign tok_val_out  = tok_val_ff;
   assign tok_idx_out  = tok_idx_ff;
   assign tok_vld_out  = tok_vld_ff;
   assign tok_mark_out = tok_mark_ff;

endmodule
`default_nettype wire

// ===== src/sliding_window_median_deviation_unit.sv =====
// Sliding-window median deviation unit.
// Samples arrive on req_ch (valid/ready, signed 32-bit sample); results leave on
// rsp_ch (valid/ready, 38-bit deviation_cost). A transaction completes when valid
// and ready are both high at a rising clock edge.
// The window length is written through the APB port at byte address 0; a write
// empties the window. The user must write only while the unit is idle; the unit
// does not enforce this. The samples live in a chain of WINDOW_MAX cells that
// shifts on each accepted sample. While the window fills, a sample yields no result.
// Once it is full, each sample runs three passes of a token ring through the chain:
// ranking, median pick and summation, then a drain state that adds the last
// difference and a hand-off state that loads the sum into the output register.
// No new sample is taken while this runs; the next one can be taken in the cycle
// after the result is registered. If the receiver stalls, the result waits in the
// output register and the next sample is still taken; a second result then waits
// until the first is taken. Reset empties the window, sets the length to 1 and
// drops any pending result.
`default_nettype none
module sliding_window_median_deviation_unit import swmd_pkg::*; #(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   swmd_req_if.sink                     req_ch,
   swmd_rsp_if.source                   rsp_ch,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire  logic [CSR_ADDR_W-1:0]  paddr,
   input  wire  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]        prdata,
   output logic                         pready
);

   `include "sliding_window_median_deviation_unit_macros.svh"

   localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LW = $clog2(WINDOW_MAX + 1);
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int DW = SAMPLE_W;
   localparam int PW = (LW > LEN_CFG_W) ? LW : LEN_CFG_W;
   localparam logic [CW-1:0] LAST_STEP = CW'(WINDOW_MAX);

   state_type state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [LW-1:0]  fill_ff, fill_in;
   logic signed [SAMPLE_W-1:0] med_ff, med_in;
   logic [DW-1:0]     diff_ff, diff_in;
   logic [COST_W-1:0] acc_ff, acc_in;
   logic [COST_W-1:0] out_ff, out_in;
   logic              out_vld_ff, out_vld_in;

   cell_ctl_type ctl;
   logic acc_clr, acc_add, diff_en, med_cap, out_load;
   logic take, cfg_wr;
   logic [LW-1:0] fill_next;
   logic [PW-1:0] wr_len;
   logic [IW-1:0] med_pos;

   logic signed [SAMPLE_W-1:0] hold_w    [WINDOW_MAX];
   logic signed [SAMPLE_W-1:0] tok_val_w [WINDOW_MAX];
   logic [IW-1:0]              tok_idx_w [WINDOW_MAX];
   logic                       tok_vld_w [WINDOW_MAX];
   logic                       tok_mark_w[WINDOW_MAX];

   logic signed [SAMPLE_W:0] dev;
   logic [SAMPLE_W:0]        dev_mag;

   assign take   = req_ch.valid && req_ch.ready;
   assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_WINDOW_LEN);
   assign pready = 1'b1;
   assign prdata = CSR_DATA_W'(len_ff);
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.deviation_cost = out_ff;

   assign fill_next = (fill_ff == len_ff) ? fill_ff : fill_ff + 1'b1;
   assign med_pos   = IW'((len_ff - 1'b1) >> 1);
   assign wr_len    = PW'(pwdata[LEN_CFG_W-1:0]);

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
         localparam int PREV = (gi == 0) ? WINDOW_MAX - 1 : gi - 1;
         swmd_cell #(
            .WINDOW_MAX (WINDOW_MAX),
            .IDX        (gi)
         ) u_cell (
            .clock         (clock),
            .ctl           (ctl),
            .win_len       (len_ff),
            .med_pos       (med_pos),
            .hold_prev     ((gi == 0) ? req_ch.sample : hold_w[PREV]),
            .hold_out      (hold_w[gi]),
            .tok_val_prev  (tok_val_w[PREV]),
            .tok_idx_prev  (tok_idx_w[PREV]),
            .tok_vld_prev  (tok_vld_w[PREV]),
            .tok_mark_prev (tok_mark_w[PREV]),
            .tok_val_out   (tok_val_w[gi]),
            .tok_idx_out   (tok_idx_w[gi]),
            .tok_vld_out   (tok_vld_w[gi]),
            .tok_mark_out  (tok_mark_w[gi])
         );
      end
   endgenerate

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && (fill_next == len_ff)) begin
               state_in = ST_RANK;
               cnt_in   = '0;
            end
         end
         ST_RANK, ST_MED, ST_SUM: begin
            if (cnt_ff == LAST_STEP) begin
               cnt_in = '0;
               case (state_ff)
                  ST_RANK: state_in = ST_MED;
                  ST_MED:  state_in = ST_SUM;
                  default: state_in = ST_DRAIN;
               endcase
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE: begin
            if (!out_vld_ff || rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      ctl      = '0;
      acc_clr  = 1'b0;
      acc_add  = 1'b0;
      diff_en  = 1'b0;
      med_cap  = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: ctl.push = take;
         ST_RANK: begin
            if (cnt_ff == '0) begin
               ctl.load     = 1'b1;
               ctl.rank_clr = 1'b1;
            end else begin
               ctl.shift   = 1'b1;
               ctl.rank_en = 1'b1;
            end
         end
         ST_MED: begin
            if (cnt_ff == '0) begin
               ctl.load = 1'b1;
            end else begin
               ctl.shift = 1'b1;
               med_cap   = 1'b1;
            end
         end
         ST_SUM: begin
            if (cnt_ff == '0) begin
               ctl.load = 1'b1;
               acc_clr  = 1'b1;
            end else begin
               ctl.shift = 1'b1;
               diff_en   = 1'b1;
               acc_add   = 1'b1;
            end
         end
         ST_DRAIN: acc_add = 1'b1;
         ST_DONE:  out_load = !out_vld_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   assign dev     = {tok_val_w[WINDOW_MAX-1][SAMPLE_W-1], tok_val_w[WINDOW_MAX-1]}
                    - {med_ff[SAMPLE_W-1], med_ff};
   assign dev_mag = dev[SAMPLE_W] ? (~dev + 1'b1) : dev;

   always_comb begin
      len_in     = len_ff;
      fill_in    = fill_ff;
      med_in     = med_ff;
      diff_in    = diff_ff;
      acc_in     = acc_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (cfg_wr) begin
         if (wr_len == '0) begin
            len_in = LW'(1);
         end else if (wr_len > PW'(WINDOW_MAX)) begin
            len_in = LW'(WINDOW_MAX);
         end else begin
            len_in = LW'(wr_len);
         end
         fill_in = '0;
      end else if (take) begin
         fill_in = fill_next;
      end
      if (med_cap && tok_mark_w[WINDOW_MAX-1]) begin
         med_in = tok_val_w[WINDOW_MAX-1];
      end
      if (acc_clr) begin
         diff_in = '0;
         acc_in  = '0;
      end else begin
         if (diff_en) begin
            diff_in = tok_vld_w[WINDOW_MAX-1] ? dev_mag[DW-1:0] : '0;
         end
         if (acc_add) begin
            acc_in = acc_ff + COST_W'(diff_ff);
         end
      end
      if (out_load) begin
         out_in     = acc_ff;
         out_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         len_ff     <= LW'(1);
         fill_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         len_ff     <= len_in;
         fill_ff    <= fill_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      med_ff  <= med_in;
      diff_ff <= diff_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
   end

   `SWMD_ASSERT(a_fill_bound, fill_ff <= len_ff, "fill count exceeds window length")
   `SWMD_ASSERT(a_busy_full, (state_ff != ST_IDLE) |-> (fill_ff == len_ff),
      "computation running on a window that is not full")
   `SWMD_ASSERT(a_rsp_from_done, $rose(out_vld_ff) |-> $past(state_ff == ST_DONE),
      "result raised outside the hand-off state")
   `SWMD_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !out_vld_ff),
      "unit not idle after reset")

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import swmd_pkg::*;

   localparam int WIN_MAX    = WINDOW_MAX_DEF;
   localparam int ITEM_LAT   = 3 * WIN_MAX + 10;
   localparam int CYCLE_CAP  = 1000000;
   localparam int RAND_ITEMS = 800;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

   typedef enum logic [1:0] {ROW_SAMPLE, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] value;
      logic signed [SAMPLE_W-1:0] sample;
      bit                  typed;
      logic [COST_W-1:0]   cost;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   swmd_req_if req_ch ();
   swmd_rsp_if rsp_ch ();

   sliding_window_median_deviation_unit u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Predictor state: window contents in ring order and the programmed length.
   longint win_ring [WIN_MAX];
   int unsigned win_len = 1;
   int unsigned win_fill = 0;
   int unsigned win_oldest = 0;
   logic [COST_W-1:0] pending_costs [$];
   int errors = 0;
   int costs_seen = 0;
   longint cycle_count = 0;
   bit calm;

   initial begin
      req_ch.valid = 0;
      req_ch.sample = '0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("FAILURE");
         $finish;
      end
   end

   // No idling on either side inside this stretch of cycles.
   assign calm = (cycle_count >= 30000) && (cycle_count < 45000);

   function automatic logic [COST_W-1:0] median_deviation();
      longint sorted [WIN_MAX];
      longint v, med;
      longint unsigned sum;
      int j;
      sum = 0;
      for (int i = 0; i < win_len; i++) begin
         v = win_ring[i];
         j = i;
         while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = v;
      end
      med = sorted[(win_len - 1) / 2];
      for (int i = 0; i < win_len; i++)
         sum += (sorted[i] > med) ? sorted[i] - med : med - sorted[i];
      return sum[COST_W-1:0];
   endfunction

   // Returns 1 when the sample completes a full window.
   function automatic bit window_push(input logic signed [SAMPLE_W-1:0] s,
                                      output logic [COST_W-1:0] cost);
      if (win_fill < win_len) begin
         win_ring[(win_oldest + win_fill) % win_len] = s;
         win_fill++;
      end else begin
         win_ring[win_oldest % win_len] = s;
         win_oldest = (win_oldest + 1) % win_len;
      end
      cost = '0;
      if (win_fill < win_len) return 0;
      cost = median_deviation();
      return 1;
   endfunction

   task automatic wait_idle();
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending_costs.size() != 0) @(posedge clock);
      repeat (ITEM_LAT) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      int unsigned v;
      wait_idle();
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (addr == ADDR_WINDOW_LEN) begin
         v = value[LEN_CFG_W-1:0];
         if (v == 0) v = 1;
         if (v > WIN_MAX) v = WIN_MAX;
         win_len = v;
         win_fill = 0;
         win_oldest = 0;
      end
   endtask

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                              input logic [COST_W-1:0] typed_cost);
      logic [COST_W-1:0] cost;
      while (!calm && $urandom_range(99) < 31) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.sample <= s;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (window_push(s, cost))
         pending_costs.push_back(typed ? typed_cost : cost);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(5))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         2: return $signed($urandom_range(20)) - 10;
         3: return $urandom() ^ 32'hffff0000;
         default: return $signed({{16{1'($urandom_range(1))}}, 16'($urandom())});
      endcase
   endfunction

   // Result side: random stalls, one long hold once enough costs have arrived.
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 0;
      end else if (!hold_done && costs_seen == 60) begin
         hold_done <= 1;
         hold_left <= 500;
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= 31);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         costs_seen <= costs_seen + 1;
         if (pending_costs.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %0d",
                     $time, rsp_ch.deviation_cost);
            errors++;
         end else if (pending_costs[0] !== rsp_ch.deviation_cost) begin
            $display("%0t: deviation_cost mismatch, expected %0d, actual %0d",
                     $time, pending_costs[0], rsp_ch.deviation_cost);
            errors++;
            void'(pending_costs.pop_front());
         end else begin
            void'(pending_costs.pop_front());
         end
      end
   end

   row_type rows [] = '{
      '{ROW_SAMPLE, '0, '0, 32'sd0,          1, 38'd0},
      '{ROW_SAMPLE, '0, '0, 32'sh80000000,   1, 38'd0},
      '{ROW_SAMPLE, '0, '0, 32'sh7fffffff,   1, 38'd0},
      '{ROW_CFG, ADDR_WINDOW_LEN, 32'd2, '0, 0, '0},
      '{ROW_SAMPLE, '0, '0, 32'sh80000000,   0, '0},
      '{ROW_SAMPLE, '0, '0, 32'sh7fffffff,   1, 38'hffffffff},
      '{ROW_SAMPLE, '0, '0, -32'sd1,         1, 38'h80000000},
      '{ROW_CFG, ADDR_WINDOW_LEN, 32'd0, '0, 0, '0},
      '{ROW_SAMPLE, '0, '0, 32'sd5,          1, 38'd0},
      '{ROW_CFG, ADDR_WINDOW_LEN, 32'd3, '0, 0, '0},
      '{ROW_SAMPLE, '0, '0, 32'sd1,          0, '0},
      '{ROW_SAMPLE, '0, '0, 32'sd2,          0, '0},
      '{ROW_CFG, ADDR_UNUSED, 32'd9, '0, 0, '0},
      '{ROW_SAMPLE, '0, '0, 32'sd3,          1, 38'd2},
      '{ROW_SAMPLE, '0, '0, -32'sd7,         0, '0},
      '{ROW_CFG, ADDR_WINDOW_LEN, 32'hffffffff, '0, 0, '0},
      '{ROW_SAMPLE, '0, '0, 32'sh55aa55aa,   0, '0},
      '{ROW_CFG, ADDR_WINDOW_LEN, 32'd40, '0, 0, '0}
   };

   int unsigned lens [] = '{32, 1, 2, 3, 5, 8, 17, 31, 63, 0, 4, 6};

   initial begin
      int sent;
      int phase;
      int phase_items;
      bit paused;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CFG)
            csr_write(rows[i].addr, rows[i].value);
         else
            send_sample(rows[i].sample, rows[i].typed, rows[i].cost);
      end
      // Full window of alternating extremes gives the largest cost.
      for (int i = 0; i < 40; i++)
         send_sample(i[0] ? 32'sh7fffffff : 32'sh80000000, 0, '0);
      sent = 0;
      phase = 0;
      paused = 0;
      while (sent < RAND_ITEMS) begin
         if (phase < lens.size())
            csr_write(ADDR_WINDOW_LEN, lens[phase]);
         else if ($urandom_range(3) == 0)
            csr_write(ADDR_WINDOW_LEN, $urandom_range(63));
         else
            csr_write(ADDR_WINDOW_LEN, $urandom_range(1, 9));
         phase++;
         phase_items = $urandom_range(30, 90);
         for (int k = 0; k < phase_items; k++) begin
            if (!paused && sent >= RAND_ITEMS / 2) begin
               paused = 1;
               req_ch.valid <= 0;
               @(posedge clock);
               while (pending_costs.size() != 0) @(posedge clock);
            end
            send_sample(rand_sample(), 0, '0);
            sent++;
         end
      end
      wait_idle();
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+src
src/swmd_pkg.sv
src/swmd_req_if.sv
src/swmd_rsp_if.sv
src/swmd_cell.sv
src/sliding_window_median_deviation_unit.sv
test/testbench.sv
